// ===== hw/rtl/unta_pkg.sv =====
package unta_pkg;

  localparam int SQRT_CELLS    = 31;
  localparam int CORDIC_STAGES = 18;
  localparam int LANE_CELLS    = SQRT_CELLS + CORDIC_STAGES;

  localparam int COMP_W = 18;
  localparam int SQ_W   = 35;
  localparam int RAD_W  = 62;
  localparam int REM_W  = 34;
  localparam int ROOT_W = 31;
  localparam int XV_W   = 32;
  localparam int CW     = 35;
  localparam int ACC_W  = 27;
  localparam int IDX_W  = 5;

  localparam int IN_W  = 56;
  localparam int OUT_W = 88;

  localparam logic [32:0] ONE_SQ = 33'h1_0000_0000;
  localparam logic signed [COMP_W-1:0] ONE_Q16     = 18'sd65536;
  localparam logic signed [COMP_W-1:0] MINUS_ONE_Q16 = -18'sd65536;

  localparam logic [15:0] DEG90_U  = 16'd23040;
  localparam logic [15:0] DEG180_U = 16'd46080;
  localparam logic [16:0] DEG360_U = 17'd92160;

  localparam logic signed [ACC_W-1:0] ACC_90  = 27'sd5898240;
  localparam logic signed [ACC_W-1:0] ACC_180 = 27'sd11796480;

  typedef struct packed {
    logic [RAD_W-1:0]       rad;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic signed [XV_W-1:0] xv;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
  } cord_t;

  typedef struct packed {
    logic valid;
    logic x_hi;
    logic x_lo;
    logic y_hi;
    logic y_lo;
    logic z_hi;
    logic z_lo;
    logic rot_zero;
    logic rot_sat;
    logic x_neg;
    logic y_neg;
  } flag_t;

  // atan(2^-i) in degrees * 65536, rounded to nearest.
  function automatic logic signed [ACC_W-1:0] atan_tab(input logic [IDX_W-1:0] i);
    logic signed [ACC_W-1:0] r;
    case (i)
      5'd0:  r = 27'sd2949120;
      5'd1:  r = 27'sd1740967;
      5'd2:  r = 27'sd919879;
      5'd3:  r = 27'sd466945;
      5'd4:  r = 27'sd234379;
      5'd5:  r = 27'sd117304;
      5'd6:  r = 27'sd58666;
      5'd7:  r = 27'sd29335;
      5'd8:  r = 27'sd14668;
      5'd9:  r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;
      5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp to 0..180 degrees and round half up to 1/256 degree.
  function automatic logic [15:0] acc_to_units(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] c;
    logic [ACC_W-1:0] s;
    c = acc;
    if (acc < 0) begin
      c = '0;
    end else if (acc > ACC_180) begin
      c = ACC_180;
    end
    s = $unsigned(c) + 27'd128;
    return s[23:8];
  endfunction

endpackage

// ===== hw/rtl/unta_sqrt_cell.sv =====
module unta_sqrt_cell
  import unta_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  sq_t  d,
  output sq_t  q
);

  sq_t q_next;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic ge;

  // One result bit per cell: bring down two radicand bits, try root*4+1.
  always_comb begin
    rem_sh = {d.rem[REM_W-3:0], d.rad[RAD_W-1 -: 2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, d.root, 2'b01};
    ge     = rem_sh >= trial;
    q_next.rem  = ge ? rem_sh - trial : rem_sh;
    q_next.root = {d.root[ROOT_W-2:0], ge};
    q_next.rad  = {d.rad[RAD_W-3:0], 2'b00};
    q_next.xv   = d.xv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== hw/rtl/unta_cordic_cell.sv =====
module unta_cordic_cell
  import unta_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] stage,
  input  cord_t            d,
  output cord_t            q
);

  cord_t q_next;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  always_comb begin
    xs = d.x >>> stage;
    ys = d.y >>> stage;
    if (!d.y[CW-1]) begin
      q_next.x   = d.x + ys;
      q_next.y   = d.y - xs;
      q_next.acc = d.acc + atan_tab(stage);
    end else begin
      q_next.x   = d.x - ys;
      q_next.y   = d.y + xs;
      q_next.acc = d.acc - atan_tab(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== hw/rtl/unta_lane.sv =====
module unta_lane
  import unta_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [RAD_W-1:0]        rad,
  input  logic signed [XV_W-1:0]  xv,
  output logic signed [ACC_W-1:0] acc
);

  sq_t   sq [SQRT_CELLS+1];
  cord_t cd [CORDIC_STAGES+1];
  logic signed [CW-1:0] yv;
  logic signed [CW-1:0] xe;

  assign sq[0].rad  = rad;
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;
  assign sq[0].xv   = xv;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    unta_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (sq[i]),
      .q   (sq[i+1])
    );
  end

  // A negative x is rotated by 90 degrees first so the CORDIC converges.
  always_comb begin
    yv = $signed({{(CW-ROOT_W){1'b0}}, sq[SQRT_CELLS].root});
    xe = CW'(sq[SQRT_CELLS].xv);
    if (xe < 0) begin
      cd[0].x   = yv;
      cd[0].y   = -xe;
      cd[0].acc = ACC_90;
    end else begin
      cd[0].x   = xe;
      cd[0].y   = yv;
      cd[0].acc = '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    unta_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .stage (IDX_W'(i)),
      .d     (cd[i]),
      .q     (cd[i+1])
    );
  end

  assign acc = cd[CORDIC_STAGES].acc;

endmodule

// ===== hw/rtl/unit_normal_to_angles.sv =====
// A request passes two prepare stages, 31 square-root cells, 18 CORDIC cells
// and one output stage on its way to the master side. Throughput: one request
// per cycle unless stalled; all four arc lanes are fully pipelined.
// A skid register lets one more result land while the output is stalled.
// Reset (rst, synchronous) clears the valid bits and flags, not the data.
module unit_normal_to_angles
  import unta_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // x_component[17:0], y_component[35:18], z_component[53:36], zero[55:54]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // x_axis_angle[15:0], y_axis_angle[31:16], z_axis_angle[47:32],
  // rotation_angle[64:48], fallback_angle[80:65], zero[87:81]
  output logic [OUT_W-1:0] m_tdata
);

  logic en;

  logic                     a_valid;
  logic signed [COMP_W-1:0] a_x, a_y, a_z;
  logic [SQ_W-1:0]          a_xsq, a_ysq, a_zsq;
  logic signed [2*COMP_W-1:0] px, py, pz;

  flag_t                  b_flags;
  flag_t                  b_flags_next;
  logic [RAD_W-1:0]       b_rad_x, b_rad_y, b_rad_z, b_rad_r;
  logic signed [XV_W-1:0] b_xv_x, b_xv_y, b_xv_z;
  logic [32:0]            zc2, c2;

  flag_t fl [LANE_CELLS];
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_z, acc_r;

  logic [15:0] ang_x, ang_y, ang_z, rot_u, fb;
  logic [16:0] rot;
  logic [OUT_W-1:0] res;
  logic out_free;
  logic skid_valid;
  logic [OUT_W-1:0] skid_data;

  assign en       = !skid_valid;
  assign s_tready = en;

  always_comb begin
    px = $signed(s_tdata[17:0]) * $signed(s_tdata[17:0]);
    py = $signed(s_tdata[35:18]) * $signed(s_tdata[35:18]);
    pz = $signed(s_tdata[53:36]) * $signed(s_tdata[53:36]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x   <= $signed(s_tdata[17:0]);
      a_y   <= $signed(s_tdata[35:18]);
      a_z   <= $signed(s_tdata[53:36]);
      a_xsq <= px[SQ_W-1:0];
      a_ysq <= py[SQ_W-1:0];
      a_zsq <= pz[SQ_W-1:0];
    end
  end

  always_comb begin
    b_flags_next.valid = a_valid;
    b_flags_next.x_hi  = a_x >= ONE_Q16;
    b_flags_next.x_lo  = a_x <= MINUS_ONE_Q16;
    b_flags_next.y_hi  = a_y >= ONE_Q16;
    b_flags_next.y_lo  = a_y <= MINUS_ONE_Q16;
    b_flags_next.z_hi  = a_z >= ONE_Q16;
    b_flags_next.z_lo  = a_z <= MINUS_ONE_Q16;
    // z is clamped to plus or minus one before cos(elevation) squared is formed.
    zc2 = (b_flags_next.z_hi || b_flags_next.z_lo) ? ONE_SQ : a_zsq[32:0];
    c2  = ONE_SQ - zc2;
    b_flags_next.rot_zero = c2 == 33'd0;
    b_flags_next.rot_sat  = a_xsq >= {2'b00, c2};
    b_flags_next.x_neg    = a_x[COMP_W-1];
    b_flags_next.y_neg    = a_y[COMP_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_flags <= '0;
    end else if (en) begin
      b_flags <= b_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_rad_x <= {1'b0, ONE_SQ - a_xsq[32:0], 28'd0};
      b_rad_y <= {1'b0, ONE_SQ - a_ysq[32:0], 28'd0};
      b_rad_z <= {1'b0, ONE_SQ - a_zsq[32:0], 28'd0};
      b_rad_r <= {1'b0, c2 - a_xsq[32:0], 28'd0};
      b_xv_x  <= $signed({a_x, 14'd0});
      b_xv_y  <= $signed({a_y, 14'd0});
      b_xv_z  <= $signed({a_z, 14'd0});
    end
  end

  unta_lane u_lane_x (.clk(clk), .en(en), .rad(b_rad_x), .xv(b_xv_x), .acc(acc_x));
  unta_lane u_lane_y (.clk(clk), .en(en), .rad(b_rad_y), .xv(b_xv_y), .acc(acc_y));
  unta_lane u_lane_z (.clk(clk), .en(en), .rad(b_rad_z), .xv(b_xv_z), .acc(acc_z));
  unta_lane u_lane_r (.clk(clk), .en(en), .rad(b_rad_r), .xv(b_xv_x), .acc(acc_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANE_CELLS; k++) begin
        fl[k] <= '0;
      end
    end else if (en) begin
      fl[0] <= b_flags;
      for (int k = 1; k < LANE_CELLS; k++) begin
        fl[k] <= fl[k-1];
      end
    end
  end

  always_comb begin
    ang_x = fl[LANE_CELLS-1].x_hi ? 16'd0 :
            fl[LANE_CELLS-1].x_lo ? DEG180_U : acc_to_units(acc_x);
    ang_y = fl[LANE_CELLS-1].y_hi ? 16'd0 :
            fl[LANE_CELLS-1].y_lo ? DEG180_U : acc_to_units(acc_y);
    ang_z = fl[LANE_CELLS-1].z_hi ? 16'd0 :
            fl[LANE_CELLS-1].z_lo ? DEG180_U : acc_to_units(acc_z);
    if (fl[LANE_CELLS-1].rot_zero) begin
      rot_u = 16'd0;
    end else if (fl[LANE_CELLS-1].rot_sat) begin
      rot_u = fl[LANE_CELLS-1].x_neg ? DEG180_U : 16'd0;
    end else begin
      rot_u = acc_to_units(acc_r);
    end
    rot = fl[LANE_CELLS-1].y_neg ? DEG360_U - {1'b0, rot_u} : {1'b0, rot_u};
    fb  = DEG90_U - ang_z;
    res = {7'd0, fb, rot, ang_z, ang_y, ang_x};
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (fl[LANE_CELLS-1].valid) begin
      if (out_free) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        m_tdata <= skid_data;
      end
    end else if (fl[LANE_CELLS-1].valid) begin
      if (out_free) begin
        m_tdata <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

`ifndef SYNTHESIS
  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[64:48] <= DEG360_U)
    else $error("rotation angle above 360 degrees");

  a_fallback: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[80:65] == 16'(DEG90_U - m_tdata[47:32]))
    else $error("elevation does not match z axis angle");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid register filled without an output stall");
`endif

endmodule
